// ----- rtl/xbts_pkg.sv -----
// Shared constants, types and codes for the x86 branch target splitter.
// No dependencies; the top level and the testbench import this package.
`timescale 1ns / 1ps

package xbts_pkg;

  localparam int unsigned MAX_IMAGE_BYTES = 16777216;
  localparam int unsigned REGION_BITS     = 11;
  localparam int unsigned REGION_DEPTH    = (MAX_IMAGE_BYTES >> REGION_BITS) + 1;
  localparam int unsigned REGION_AW       = $clog2(REGION_DEPTH);
  localparam int unsigned IDX_W           = 32 - REGION_BITS;

  localparam int unsigned LEN_W   = 24;
  localparam int unsigned WIN_LEN = 6;
  localparam int unsigned CNT_W   = 2;

  localparam int unsigned FIFO_DEPTH = 4;
  localparam int unsigned FIFO_AW    = 2;

  localparam logic [7:0] OP_CALL  = 8'hE8;
  localparam logic [7:0] OP_JMP   = 8'hE9;
  localparam logic [7:0] OP_ESC   = 8'h0F;
  localparam logic [7:0] JCC_MASK = 8'hF0;
  localparam logic [7:0] JCC_BASE = 8'h80;

  localparam logic [31:0] HALF_REGION = 32'(1) << (REGION_BITS - 1);

  localparam logic [2:0]       SKIP_CONV = 3'd4;
  localparam logic [CNT_W-1:0] CNT_SAT   = 2'd3;
  localparam logic [CNT_W-1:0] CNT_HOT   = 2'd2;

  localparam logic FLAG_CONVERTED = 1'b0;
  localparam logic FLAG_KEPT      = 1'b1;

  typedef enum logic [1:0] {
    STREAM_MAIN = 2'd0,
    STREAM_FLAG = 2'd1,
    STREAM_CALL = 2'd2,
    STREAM_JUMP = 2'd3
  } stream_e;

  typedef enum logic [1:0] {
    KIND_NONE = 2'd0,
    KIND_CALL = 2'd1,
    KIND_JUMP = 2'd2
  } kind_e;

  // one decided byte of the emit pass: main beat, optional flag, optional target
  typedef struct packed {
    logic [7:0]  code_byte;
    logic        has_flag;
    logic        conv;
    logic        is_call;
    logic [31:0] target;
    logic        last;
  } rec_t;

endpackage

// ----- rtl/xbts_if.sv -----
// Valid/ready channel interfaces for the input bytes and the result beats.
// Depends on nothing.
`timescale 1ns / 1ps

interface xbts_in_if;
  logic       valid;
  logic       ready;
  logic       cmd;
  logic [7:0] code_byte;
  logic       last_byte;

  modport source (output valid, cmd, code_byte, last_byte, input ready);
  modport sink (input valid, cmd, code_byte, last_byte, output ready);
endinterface

interface xbts_out_if;
  logic        valid;
  logic        ready;
  logic [1:0]  stream_id;
  logic [31:0] out_value;
  logic        end_of_run;

  modport source (output valid, stream_id, out_value, end_of_run, input ready);
  modport sink (input valid, stream_id, out_value, end_of_run, output ready);
endinterface

// ----- rtl/xbts_ram.sv -----
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`timescale 1ns / 1ps

module xbts_ram #(
  parameter int unsigned WIDTH = 2,
  parameter int unsigned DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ----- rtl/x86_branch_target_splitter.sv -----
// x86 branch target splitter top level: window, decide stages, region tables.
// Depends on xbts_pkg, xbts_if and xbts_ram.
//
// After reset it clears all 8193 entries of both region tables, then takes one
// code byte per cycle in both passes unless flushing or a full queue stalls it.
// Each byte is decided once it has five bytes behind it (or in the end-of-pass
// flush, one held byte per cycle while the queue has room, with no input taken).
// Decisions run in two stages: the first forms the target and reads the 2-bit
// region counter from the call or jump table, the second finishes the conversion
// and, in the count pass, writes the bumped counter back. Results leave one beat
// per cycle while the output is ready; an unskipped emit pass byte gives one
// beat, two with a flag, three with a converted target, held in a four-record queue.
`timescale 1ns / 1ps

module x86_branch_target_splitter
  import xbts_pkg::*;
(
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             cfg_we_i,
  input  logic [LEN_W-1:0] cfg_wdata_i,
  xbts_in_if.sink          in_i,
  xbts_out_if.source       out_o
);

  logic                 clr_q;
  logic [REGION_AW-1:0] clr_cnt_q;
  logic [LEN_W-1:0]     len_q;

  logic [7:0] win_q [WIN_LEN];
  logic [2:0] fill_q;
  logic       flush_q;
  logic       cmd_q;
  logic [23:0] pos_q;
  logic [2:0] skip_q;

  logic                 s2_valid_q, s2_emit_q, s2_skip_q, s2_hit_q, s2_intab_q;
  logic                 s2_final_q, s2_pend_q;
  logic [7:0]           s2_byte_q;
  kind_e                s2_kind_q;
  logic [31:0]          s2_tgt_q;
  logic [REGION_AW-1:0] s2_idx_q;

  logic             fwd_q;
  logic [CNT_W-1:0] fwd_val_q;

  logic h_valid_q, h_closed_q;
  rec_t h_rec_q;

  rec_t               fifo_q [FIFO_DEPTH];
  logic [FIFO_AW-1:0] wptr_q, rptr_q;
  logic [FIFO_AW:0]   fcnt_q;
  logic [1:0]         sub_q;

  logic full, adv, acc, dec, pass_end, rec_final;
  logic [CNT_W-1:0] call_rdata, jump_rdata, cnt_rd, cnt_inc;
  logic s2_tested, s2_conv, s2_we;
  logic [2:0] skip_eff;
  logic s1_skip, near_ok, jcc_ok, dpos2;
  kind_e kind;
  logic [31:0] disp, tgt, biased;
  logic [IDX_W-1:0] idx_full;
  logic hit, intab;
  logic [REGION_AW-1:0] s1_addr;
  logic call_re, jump_re, fwd_d;
  logic call_we, jump_we;
  logic [REGION_AW-1:0] waddr;
  logic [CNT_W-1:0] wdata;

  logic r_res, push, h_valid_d, h_closed_d;
  rec_t new_rec, push_rec, h_rec_d, head;
  logic beat_last, pop, out_hs;

  assign full = fcnt_q == (FIFO_AW+1)'(FIFO_DEPTH);
  assign adv  = !full;

  // second stage: finish conversion
  assign cnt_rd    = fwd_q ? fwd_val_q : ((s2_kind_q == KIND_CALL) ? call_rdata : jump_rdata);
  assign cnt_inc   = (cnt_rd == CNT_SAT) ? CNT_SAT : cnt_rd + 2'd1;
  assign s2_tested = s2_kind_q != KIND_NONE;
  assign s2_conv   = s2_valid_q && s2_tested &&
                     (s2_emit_q ? (s2_intab_q && cnt_rd >= CNT_HOT) : s2_hit_q);
  assign s2_we     = adv && s2_valid_q && !s2_emit_q && s2_tested && s2_intab_q;

  // first stage: decide the window head
  assign skip_eff  = (s2_conv && !s2_pend_q) ? SKIP_CONV : skip_q;
  assign dec       = adv && !clr_q && (fill_q == 3'd6 || (flush_q && fill_q != 3'd0));
  assign pass_end  = flush_q && fill_q == 3'd1;
  assign rec_final = !flush_q || fill_q == 3'd1;
  assign s1_skip   = skip_eff != 3'd0;
  assign near_ok   = ({1'b0, pos_q} + 25'd8) <= {1'b0, len_q};
  assign jcc_ok    = ({1'b0, pos_q} + 25'd6) <= {1'b0, len_q};

  always_comb begin
    kind  = KIND_NONE;
    dpos2 = 1'b0;
    if (!s1_skip) begin
      if (win_q[0] == OP_CALL && near_ok) begin
        kind = KIND_CALL;
      end else if (win_q[0] == OP_JMP && near_ok) begin
        kind = KIND_JUMP;
      end else if (win_q[0] == OP_ESC && (win_q[1] & JCC_MASK) == JCC_BASE && jcc_ok) begin
        kind  = KIND_JUMP;
        dpos2 = 1'b1;
      end
    end
  end

  assign disp     = dpos2 ? {win_q[5], win_q[4], win_q[3], win_q[2]}
                          : {win_q[4], win_q[3], win_q[2], win_q[1]};
  assign tgt      = {8'd0, pos_q} + disp;
  assign hit      = tgt < 32'(len_q);
  assign biased   = tgt + HALF_REGION;
  assign idx_full = biased[31:REGION_BITS];
  assign intab    = hit && (idx_full < IDX_W'(REGION_DEPTH));
  assign s1_addr  = idx_full[REGION_AW-1:0];
  assign call_re  = dec && kind == KIND_CALL && intab;
  assign jump_re  = dec && kind == KIND_JUMP && intab;
  // same-cycle write and read of one counter: take the written value
  assign fwd_d    = (call_re || jump_re) && s2_we && s2_kind_q == kind && s2_idx_q == s1_addr;

  assign call_we = clr_q || (s2_we && s2_kind_q == KIND_CALL);
  assign jump_we = clr_q || (s2_we && s2_kind_q == KIND_JUMP);
  assign waddr   = clr_q ? clr_cnt_q : s2_idx_q;
  assign wdata   = clr_q ? '0 : cnt_inc;

  xbts_ram #(.WIDTH(CNT_W), .DEPTH(REGION_DEPTH)) u_call_ram (
    .clk_i   (clk_i),
    .we_i    (call_we),
    .waddr_i (waddr),
    .wdata_i (wdata),
    .re_i    (call_re),
    .raddr_i (s1_addr),
    .rdata_o (call_rdata)
  );

  xbts_ram #(.WIDTH(CNT_W), .DEPTH(REGION_DEPTH)) u_jump_ram (
    .clk_i   (clk_i),
    .we_i    (jump_we),
    .waddr_i (waddr),
    .wdata_i (wdata),
    .re_i    (jump_re),
    .raddr_i (s1_addr),
    .rdata_o (jump_rdata)
  );

  assign in_i.ready = !clr_q && !flush_q && (fill_q != 3'd6 || dec);
  assign acc        = in_i.valid && in_i.ready;

  // hold the latest result record until its input is known to be done
  assign r_res = s2_valid_q && s2_emit_q && !s2_skip_q;

  always_comb begin
    new_rec           = '0;
    new_rec.code_byte = s2_byte_q;
    new_rec.has_flag  = s2_tested;
    new_rec.conv      = s2_conv;
    new_rec.is_call   = s2_kind_q == KIND_CALL;
    new_rec.target    = s2_tgt_q;
    push_rec          = h_rec_q;
    push_rec.last     = h_closed_q;
    push              = 1'b0;
    h_valid_d         = h_valid_q;
    h_closed_d        = h_closed_q;
    h_rec_d           = h_rec_q;
    if (adv) begin
      if (r_res) begin
        push       = h_valid_q;
        h_valid_d  = 1'b1;
        h_rec_d    = new_rec;
        h_closed_d = s2_final_q;
      end else if (h_valid_q && h_closed_q) begin
        push      = 1'b1;
        h_valid_d = 1'b0;
      end else if (s2_valid_q && s2_final_q && h_valid_q) begin
        h_closed_d = 1'b1;
      end
    end
  end

  // result beats from the queue head
  assign head = fifo_q[rptr_q];

  always_comb begin
    beat_last = 1'b0;
    out_o.stream_id = STREAM_MAIN;
    out_o.out_value = {24'd0, head.code_byte};
    case (sub_q)
      2'd0: begin
        beat_last = !head.has_flag;
      end
      2'd1: begin
        beat_last = !head.conv;
        out_o.stream_id = STREAM_FLAG;
        out_o.out_value = {31'd0, head.conv ? FLAG_CONVERTED : FLAG_KEPT};
      end
      2'd2: begin
        beat_last = 1'b1;
        out_o.stream_id = head.is_call ? STREAM_CALL : STREAM_JUMP;
        out_o.out_value = head.target;
      end
      default: begin
        beat_last = 1'b1;
      end
    endcase
  end

  assign out_o.valid      = fcnt_q != '0;
  assign out_o.end_of_run = head.last && beat_last;
  assign out_hs           = out_o.valid && out_o.ready;
  assign pop              = out_hs && beat_last;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_q      <= 1'b1;
      clr_cnt_q  <= '0;
      len_q      <= '0;
      fill_q     <= '0;
      flush_q    <= 1'b0;
      cmd_q      <= 1'b0;
      pos_q      <= '0;
      skip_q     <= '0;
      s2_valid_q <= 1'b0;
      fwd_q      <= 1'b0;
      h_valid_q  <= 1'b0;
      h_closed_q <= 1'b0;
      wptr_q     <= '0;
      rptr_q     <= '0;
      fcnt_q     <= '0;
      sub_q      <= '0;
      for (int i = 0; i < WIN_LEN; i++) begin
        win_q[i] <= '0;
      end
    end else begin
      if (cfg_we_i) begin
        len_q <= cfg_wdata_i;
      end
      if (clr_q) begin
        clr_cnt_q <= clr_cnt_q + REGION_AW'(1);
        if (clr_cnt_q == REGION_AW'(REGION_DEPTH - 1)) begin
          clr_q <= 1'b0;
        end
      end

      if (dec) begin
        for (int i = 0; i < WIN_LEN - 1; i++) begin
          win_q[i] <= win_q[i+1];
        end
        win_q[WIN_LEN-1] <= '0;
      end
      if (acc) begin
        win_q[dec ? fill_q - 3'd1 : fill_q] <= in_i.code_byte;
        cmd_q <= in_i.cmd;
        if (in_i.last_byte) begin
          flush_q <= 1'b1;
        end
      end
      fill_q <= fill_q - {2'd0, dec} + {2'd0, acc};
      if (dec && pass_end) begin
        flush_q <= 1'b0;
      end

      if (adv) begin
        if (dec) begin
          pos_q  <= pass_end ? '0 : pos_q + 24'd1;
          skip_q <= pass_end ? '0 : (s1_skip ? skip_eff - 3'd1 : 3'd0);
        end else begin
          skip_q <= skip_eff;
        end
        s2_valid_q <= dec;
        s2_emit_q  <= cmd_q;
        s2_skip_q  <= s1_skip;
        s2_byte_q  <= win_q[0];
        s2_kind_q  <= kind;
        s2_tgt_q   <= tgt;
        s2_hit_q   <= hit;
        s2_intab_q <= intab;
        s2_idx_q   <= s1_addr;
        s2_final_q <= rec_final;
        s2_pend_q  <= pass_end;
        fwd_q      <= fwd_d;
        fwd_val_q  <= cnt_inc;
      end

      h_valid_q  <= h_valid_d;
      h_closed_q <= h_closed_d;
      h_rec_q    <= h_rec_d;

      if (push) begin
        fifo_q[wptr_q] <= push_rec;
        wptr_q <= wptr_q + FIFO_AW'(1);
      end
      if (pop) begin
        rptr_q <= rptr_q + FIFO_AW'(1);
      end
      fcnt_q <= fcnt_q + {{FIFO_AW{1'b0}}, push} - {{FIFO_AW{1'b0}}, pop};
      if (out_hs) begin
        sub_q <= beat_last ? 2'd0 : sub_q + 2'd1;
      end
    end
  end

  a_no_input_while_clearing: assert property (@(posedge clk_i) disable iff (!rst_ni)
    clr_q |-> !in_i.ready)
    else $error("input taken during table clear");

  a_pass_end_resets: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (dec && pass_end) |=> (pos_q == '0 && skip_q == '0 && !flush_q))
    else $error("pass end did not reset position state");

  a_fill_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (fill_q <= 3'd6) && (fcnt_q <= (FIFO_AW+1)'(FIFO_DEPTH)))
    else $error("window or queue overflow");

endmodule

// ----- tb/tb_x86_branch_target_splitter.sv -----
// Self-checking testbench for x86_branch_target_splitter: count and emit passes
// over small code images, predicted in-bench and checked beat by beat.
// Depends on xbts_pkg, xbts_if and the block's RTL.
`timescale 1ns / 1ps

module tb_x86_branch_target_splitter;
  import xbts_pkg::*;

  typedef struct {
    logic       cmd;
    logic [7:0] code_byte;
    logic       last_byte;
  } code_beat_t;

  typedef struct {
    stream_e     sid;
    logic [31:0] value;
    logic        eor;
  } out_beat_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic cfg_we_i = 1'b0;
  logic [LEN_W-1:0] cfg_wdata_i = '0;

  xbts_in_if  in_bus ();
  xbts_out_if out_bus ();

  x86_branch_target_splitter DUT (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_wdata_i(cfg_wdata_i),
    .in_i       (in_bus),
    .out_o      (out_bus)
  );

  always #5 clk_i = ~clk_i;

  code_beat_t code_q[$];
  out_beat_t  beats_due[$];
  int errors = 0;
  int n_in = 0;
  int n_out = 0;
  int n_cfg = 0;
  int cycles = 0;
  bit calm = 1'b0;

  // predictor state
  logic [CNT_W-1:0] call_cnt [REGION_DEPTH];
  logic [CNT_W-1:0] jump_cnt [REGION_DEPTH];
  logic [7:0]       win [WIN_LEN];
  int               fill;
  logic [LEN_W-1:0] pos;
  int               skip_left;
  logic [LEN_W-1:0] img_len;

  initial begin
    for (int i = 0; i < REGION_DEPTH; i++) begin
      call_cnt[i] = '0;
      jump_cnt[i] = '0;
    end
    for (int i = 0; i < WIN_LEN; i++) win[i] = '0;
    fill = 0;
    pos = '0;
    skip_left = 0;
    img_len = '0;
  end

  function automatic void push_beat(stream_e sid, logic [31:0] v);
    out_beat_t e;
    e.sid = sid;
    e.value = v;
    e.eor = 1'b0;
    beats_due.push_back(e);
  endfunction

  function automatic void resolve_head(logic emit);
    logic [7:0]  b;
    kind_e       kind;
    int          dpos;
    logic [31:0] a, idx, p32, l32;
    bit          hit, in_tab;
    logic [1:0]  c;
    b = win[0];
    p32 = {8'd0, pos};
    l32 = {8'd0, img_len};
    if (skip_left > 0) begin
      skip_left--;
    end else begin
      kind = KIND_NONE;
      dpos = 1;
      if (emit) push_beat(STREAM_MAIN, {24'd0, b});
      if (b == OP_CALL && p32 + 32'd8 <= l32) begin
        kind = KIND_CALL;
      end else if (b == OP_JMP && p32 + 32'd8 <= l32) begin
        kind = KIND_JUMP;
      end else if (b == OP_ESC && (win[1] & JCC_MASK) == JCC_BASE && p32 + 32'd6 <= l32) begin
        kind = KIND_JUMP;
        dpos = 2;
      end
      if (kind != KIND_NONE) begin
        a = p32 + {win[dpos+3], win[dpos+2], win[dpos+1], win[dpos]};
        hit = a < l32;
        idx = (a + HALF_REGION) >> REGION_BITS;
        in_tab = hit && idx < REGION_DEPTH;
        c = '0;
        if (in_tab) c = (kind == KIND_CALL) ? call_cnt[idx] : jump_cnt[idx];
        if (!emit) begin
          if (in_tab && c < CNT_SAT) begin
            if (kind == KIND_CALL) call_cnt[idx] = c + 2'd1;
            else jump_cnt[idx] = c + 2'd1;
          end
          if (hit) skip_left = SKIP_CONV;
        end else if (in_tab && c >= CNT_HOT) begin
          push_beat(STREAM_FLAG, {31'd0, FLAG_CONVERTED});
          push_beat(kind == KIND_CALL ? STREAM_CALL : STREAM_JUMP, a);
          skip_left = SKIP_CONV;
        end else begin
          push_beat(STREAM_FLAG, {31'd0, FLAG_KEPT});
        end
      end
    end
    for (int k = 0; k < WIN_LEN - 1; k++) win[k] = win[k+1];
    win[WIN_LEN-1] = '0;
    if (fill > 0) fill--;
    pos = pos + 1'b1;
  endfunction

  function automatic void filter_step(code_beat_t it);
    int n0;
    n0 = beats_due.size();
    if (fill >= WIN_LEN) resolve_head(it.cmd);
    win[fill] = it.code_byte;
    fill++;
    if (it.last_byte) begin
      while (fill > 0) resolve_head(it.cmd);
      for (int k = 0; k < WIN_LEN; k++) win[k] = '0;
      pos = '0;
      skip_left = 0;
    end else if (fill == WIN_LEN) begin
      resolve_head(it.cmd);
    end
    if (beats_due.size() > n0) beats_due[beats_due.size()-1].eor = 1'b1;
  endfunction

  // driver
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_bus.valid <= 1'b0;
      in_bus.cmd <= 1'b0;
      in_bus.code_byte <= '0;
      in_bus.last_byte <= 1'b0;
    end else begin
      if (in_bus.valid && in_bus.ready) begin
        filter_step(code_q.pop_front());
        n_in++;
      end
      // a waiting beat stays on the bus until taken
      if (!(in_bus.valid && !in_bus.ready)) begin
        if (code_q.size() > 0 && (calm || $urandom_range(99) >= 14)) begin
          in_bus.valid <= 1'b1;
          in_bus.cmd <= code_q[0].cmd;
          in_bus.code_byte <= code_q[0].code_byte;
          in_bus.last_byte <= code_q[0].last_byte;
        end else begin
          in_bus.valid <= 1'b0;
        end
      end
    end
  end

  // monitor
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_bus.ready <= 1'b0;
    end else begin
      cycles++;
      if (out_bus.valid && out_bus.ready) begin
        n_out++;
        if (beats_due.size() == 0) begin
          $display("%0t unexpected beat: stream %0d value %h eor %b", $time,
                   out_bus.stream_id, out_bus.out_value, out_bus.end_of_run);
          errors++;
        end else begin
          out_beat_t e;
          e = beats_due.pop_front();
          if (out_bus.stream_id !== e.sid || out_bus.out_value !== e.value ||
              out_bus.end_of_run !== e.eor) begin
            $display("%0t mismatch: expected stream %0d value %h eor %b, got %0d %h %b",
                     $time, e.sid, e.value, e.eor, out_bus.stream_id,
                     out_bus.out_value, out_bus.end_of_run);
            errors++;
          end
        end
      end
      out_bus.ready <= calm || $urandom_range(99) >= 14;
      if (cycles > 400000) begin
        $display("timeout with %0d beats still due", beats_due.size());
        $display("[x86_branch_target_splitter] ERROR");
        $finish;
      end
    end
  end

  task automatic wait_idle();
    wait (code_q.size() == 0 && beats_due.size() == 0);
    repeat (20) @(posedge clk_i);
  endtask

  task automatic write_len(logic [LEN_W-1:0] v);
    wait_idle();
    @(posedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_wdata_i <= v;
    img_len = v;
    n_cfg++;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  // queue one pass over img; noise randomizes cmd per byte
  task automatic queue_pass(logic [7:0] img[], logic cmd, bit noise);
    code_beat_t it;
    foreach (img[i]) begin
      it.cmd = noise ? logic'($urandom_range(1)) : cmd;
      it.code_byte = img[i];
      it.last_byte = (i == img.size() - 1);
      code_q.push_back(it);
    end
  endtask

  task automatic make_image(int n, logic [LEN_W-1:0] lim, ref logic [7:0] img[]);
    logic [31:0] hot [2];
    logic [31:0] tgt, d;
    int i, k;
    img = new[n];
    for (int h = 0; h < 2; h++) hot[h] = (lim == 0) ? 32'd0 : $urandom_range(lim - 1);
    i = 0;
    while (i < n) begin
      if (i + 6 <= n && $urandom_range(3) == 0) begin
        k = $urandom_range(2);
        tgt = ($urandom_range(4) == 0) ? $urandom : hot[$urandom_range(1)];
        if (k == 2) begin
          img[i] = OP_ESC;
          img[i+1] = JCC_BASE | 8'($urandom_range(15));
          i += 2;
        end else begin
          img[i] = (k == 0) ? OP_CALL : OP_JMP;
          i += 1;
        end
        d = tgt - 32'(i - ((k == 2) ? 2 : 1));
        for (int j = 0; j < 4 && i < n; j++) begin
          img[i] = d[8*j +: 8];
          i++;
        end
      end else begin
        img[i] = 8'($urandom);
        i++;
      end
    end
  endtask

  initial begin
    logic [7:0] img[];
    logic [LEN_W-1:0] lim;
    int n;
    int rnd;
    rnd = 0;
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;

    // zero length: nothing is in bounds; also a one-byte pass
    write_len('0);
    img = {OP_CALL, 8'h01, 8'h00, 8'h00, 8'h00, OP_JMP, 8'hFF, 8'h0F, 8'h80};
    queue_pass(img, 1'b0, 0);
    queue_pass(img, 1'b1, 0);
    img = {OP_CALL};
    queue_pass(img, 1'b1, 0);

    // full length: top region, calls, jumps, Jcc, non-Jcc escape, target past end
    write_len(24'hFFFFFF);
    img = {OP_CALL, 8'hF0, 8'hFF, 8'hFF, 8'h00,
           OP_JMP, 8'h00, 8'h10, 8'h00, 8'h00,
           OP_ESC, 8'h8F, 8'h00, 8'h10, 8'h00, 8'h00,
           OP_ESC, 8'h7F, OP_CALL, 8'hFF, 8'hFF, 8'hFF, 8'h7F, 8'hAA};
    repeat (4) queue_pass(img, 1'b0, 0);
    queue_pass(img, 1'b1, 0);

    calm = 1'b0;
    while (n_in + code_q.size() < 420) begin
      wait_idle();
      // one round runs with both sides always ready
      calm = (rnd == 1);
      rnd++;
      n = $urandom_range(12, 48);
      case ($urandom_range(5))
        0: lim = 24'($urandom_range(n));
        1: lim = 24'hFFFFFF;
        2: lim = 24'($urandom);
        default: lim = 24'(n);
      endcase
      if ($urandom_range(2) == 0 || n_cfg < 3) write_len(lim);
      make_image(n, img_len, img);
      repeat ($urandom_range(1, 2)) queue_pass(img, 1'b0, 0);
      if ($urandom_range(7) == 0) queue_pass(img, 1'b0, 1);
      if ($urandom_range(9) == 0) begin
        img = new[$urandom_range(1, 7)] (img);
        queue_pass(img, 1'b1, 0);
      end else begin
        queue_pass(img, 1'b1, 0);
      end
    end

    wait_idle();
    $display("covered %0d code beats, %0d result beats, %0d length settings",
             n_in, n_out, n_cfg);
    if (errors == 0) begin
      $display("[x86_branch_target_splitter] OK");
    end else begin
      $display("[x86_branch_target_splitter] ERROR");
    end
    $finish;
  end

endmodule

// ----- files.f -----
rtl/xbts_pkg.sv
rtl/xbts_if.sv
rtl/xbts_ram.sv
rtl/x86_branch_target_splitter.sv
tb/tb_x86_branch_target_splitter.sv
